// ===== rtl/cnm_pkg.sv =====
// Shared types and constants for the CAN network-management node monitor.
// Used by the monitor top level and its port checker; no dependencies.
package cnm_pkg;

	localparam int MAX_PEERS = 256;
	localparam int TIME_BITS = 32;
	localparam int PEER_BITS = $clog2(MAX_PEERS);
	localparam int CNT_BITS  = 9;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// Register map, word index into the APB space
	typedef enum logic [2:0] {
		REG_NETWORK_NEED   = 3'd0,
		REG_OWN_NODE_ID    = 3'd1,
		REG_ID_WINDOW_BASE = 3'd2,
		REG_OFFLINE_TMO    = 3'd3,
		REG_SEND_PERIOD    = 3'd4
	} reg_idx_t;

	localparam logic        RST_NETWORK_NEED = 1'b1;
	localparam logic [7:0]  RST_OWN_NODE_ID  = 8'd1;
	localparam logic [10:0] RST_ID_BASE      = 11'd1280;
	localparam logic [15:0] RST_OFFLINE_TMO  = 16'd1000;
	localparam logic [15:0] RST_SEND_PERIOD  = 16'd100;

	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [10:0] can_id;
		logic [7:0]  ctrl_byte;
		logic [7:0]  query_node;
		logic        tx_free;
	} item_t;

	typedef struct packed {
		logic                send_frame;
		logic                tx_repeat_bit;
		logic                frame_accepted;
		logic                all_can_sleep;
		logic [CNT_BITS-1:0] online_count;
		logic                query_online;
	} result_t;

	// One entry of the peer table memory
	typedef struct packed {
		logic                 rep_req;
		logic [TIME_BITS-1:0] last_seen;
	} peer_entry_t;

endpackage

// ===== rtl/can_network_node_monitor.sv =====
// CAN network-management node monitor: peer table, millisecond clock, send timer.
// Depends on cnm_pkg; the peer table is a synchronous memory inside this module.
//
// A frame beat passes ST_FRM_RD, ST_FRM_WR and ST_RESULT before its result (done); a
// tick beat passes ST_SCAN, ST_SEND and ST_RESULT, its timeout scan reading one peer
// table entry per cycle through the single read port.
// Throughput: one beat at a time; start is taken again in the cycle that shows done.
// Reset (arst_n low) clears config to defaults, the clock, counters and online bits;
// the peer table memory is not cleared, its entries are used only once written.
module can_network_node_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	// command channel
	input  logic                              start,
	input  cnm_pkg::item_t                    item,
	output logic                              busy,
	output logic                              done,
	output cnm_pkg::result_t                  result,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cnm_pkg::ADDR_W-1:0]        paddr,
	input  logic [cnm_pkg::DATA_W-1:0]        pwdata,
	output logic [cnm_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	localparam int PB = cnm_pkg::PEER_BITS;
	localparam int TB = cnm_pkg::TIME_BITS;
	localparam int CB = cnm_pkg::CNT_BITS;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FRM_RD = 6'b000010,
		ST_FRM_WR = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_SEND   = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q;

	// ---------------------------------------------------------------- config
	logic        need_q;
	logic [7:0]  own_id_q;
	logic [10:0] id_base_q;
	logic [15:0] tmo_q;
	logic [15:0] period_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q    <= cnm_pkg::RST_NETWORK_NEED;
			own_id_q  <= cnm_pkg::RST_OWN_NODE_ID;
			id_base_q <= cnm_pkg::RST_ID_BASE;
			tmo_q     <= cnm_pkg::RST_OFFLINE_TMO;
			period_q  <= cnm_pkg::RST_SEND_PERIOD;
		end else if (cfg_we) begin
			case (cnm_pkg::reg_idx_t'(paddr[4:2]))
				cnm_pkg::REG_NETWORK_NEED:   need_q    <= pwdata[0];
				cnm_pkg::REG_OWN_NODE_ID:    own_id_q  <= pwdata[7:0];
				cnm_pkg::REG_ID_WINDOW_BASE: id_base_q <= pwdata[10:0];
				cnm_pkg::REG_OFFLINE_TMO:    tmo_q     <= pwdata[15:0];
				cnm_pkg::REG_SEND_PERIOD:    period_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cnm_pkg::reg_idx_t'(paddr[4:2]))
			cnm_pkg::REG_NETWORK_NEED:   prdata = 32'(need_q);
			cnm_pkg::REG_OWN_NODE_ID:    prdata = 32'(own_id_q);
			cnm_pkg::REG_ID_WINDOW_BASE: prdata = 32'(id_base_q);
			cnm_pkg::REG_OFFLINE_TMO:    prdata = 32'(tmo_q);
			cnm_pkg::REG_SEND_PERIOD:    prdata = 32'(period_q);
			default:                     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- accept
	logic        accept;
	logic [10:0] node_full;
	logic        frame_hit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	// Peer index is identifier minus window base; reject below window, beyond the
	// table, and our own node.
	assign node_full = item.can_id - id_base_q;
	assign frame_hit = (item.can_id >= id_base_q)
		&& (node_full < 11'(cnm_pkg::MAX_PEERS))
		&& (node_full != 11'(own_id_q));

	// Item latched at acceptance
	logic [PB-1:0] node_q;
	logic          hit_q;
	logic          rep_q;
	logic [7:0]    query_q;
	logic          txfree_q;

	// ---------------------------------------------------------------- peer table
	// Repeat bit and last-seen time live in memory; the online bit is a flop per
	// entry so reset clears it at once and an offline entry's memory word is ignored.
	cnm_pkg::peer_entry_t mem [cnm_pkg::MAX_PEERS];
	cnm_pkg::peer_entry_t rdata_q;
	logic                 mem_re;
	logic                 mem_we;
	logic [PB-1:0]        mem_raddr;
	cnm_pkg::peer_entry_t mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[node_q] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	logic [cnm_pkg::MAX_PEERS-1:0] online_q;
	logic [CB-1:0]                 n_online_q;
	logic [CB-1:0]                 n_req_q;

	// Clock and send timer
	logic [TB-1:0] time_now_q;
	logic [TB-1:0] last_send_q;
	logic          started_q;
	logic          sent_q;
	logic          acc_q;

	// Scan: address counter plus one evaluation stage behind the memory read
	logic [PB:0]   scan_q;
	logic          scan_end;
	logic          eval_vld_s1;
	logic [PB-1:0] eval_idx_s1;
	logic [TB-1:0] elapsed;
	logic          drop_peer;

	assign scan_end  = (scan_q == (PB+1)'(cnm_pkg::MAX_PEERS));
	assign mem_re    = (state_q == ST_FRM_RD) || ((state_q == ST_SCAN) && !scan_end);
	assign mem_raddr = (state_q == ST_FRM_RD) ? node_q : scan_q[PB-1:0];

	// Only frames write, and each frame's read completes before its write, so reads
	// and writes never overlap on one entry.
	assign mem_we    = (state_q == ST_FRM_WR) && hit_q;
	assign mem_wdata = '{rep_req: rep_q, last_seen: time_now_q};

	assign elapsed   = time_now_q - rdata_q.last_seen;
	assign drop_peer = (state_q == ST_SCAN) && eval_vld_s1 && online_q[eval_idx_s1]
		&& (elapsed >= TB'(tmo_q));

	// Frame update terms
	logic was_online;
	logic old_rep;

	assign was_online = online_q[node_q];
	assign old_rep    = was_online & rdata_q.rep_req;

	// Send decision
	logic want_send;
	logic do_send;

	assign want_send = !started_q || ((time_now_q - last_send_q) >= TB'(period_q));
	assign do_send   = want_send & txfree_q;

	// Query status after the item
	logic query_online;

	assign query_online = (query_q == own_id_q)
		|| ((9'(query_q) < 9'(cnm_pkg::MAX_PEERS)) && online_q[query_q[PB-1:0]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			online_q    <= '0;
			n_online_q  <= '0;
			n_req_q     <= '0;
			time_now_q  <= '0;
			last_send_q <= '0;
			started_q   <= 1'b0;
			sent_q      <= 1'b0;
			acc_q       <= 1'b0;
			hit_q       <= 1'b0;
			scan_q      <= '0;
			eval_vld_s1 <= 1'b0;
			done        <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sent_q <= 1'b0;
						acc_q  <= 1'b0;
						hit_q  <= frame_hit;
						if (item.action == cnm_pkg::ACT_TICK) begin
							// Advance the clock before the timeout scan
							time_now_q  <= time_now_q + 1'b1;
							scan_q      <= '0;
							eval_vld_s1 <= 1'b0;
							state_q     <= ST_SCAN;
						end else begin
							state_q <= ST_FRM_RD;
						end
					end
				end
				ST_FRM_RD: begin
					state_q <= ST_FRM_WR;
				end
				ST_FRM_WR: begin
					if (hit_q) begin
						online_q[node_q] <= 1'b1;
						acc_q            <= 1'b1;
						if (!was_online)
							n_online_q <= n_online_q + 1'b1;
						if (old_rep && !rep_q)
							n_req_q <= n_req_q - 1'b1;
						else if (!old_rep && rep_q)
							n_req_q <= n_req_q + 1'b1;
					end
					state_q <= ST_RESULT;
				end
				ST_SCAN: begin
					if (drop_peer) begin
						online_q[eval_idx_s1] <= 1'b0;
						n_online_q            <= n_online_q - 1'b1;
						if (rdata_q.rep_req)
							n_req_q <= n_req_q - 1'b1;
					end
					if (scan_end) begin
						eval_vld_s1 <= 1'b0;
						state_q     <= ST_SEND;
					end else begin
						eval_vld_s1 <= 1'b1;
						scan_q      <= scan_q + 1'b1;
					end
				end
				ST_SEND: begin
					started_q <= 1'b1;
					sent_q    <= do_send;
					if (do_send)
						last_send_q <= time_now_q;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			node_q   <= node_full[PB-1:0];
			rep_q    <= item.ctrl_byte[0];
			query_q  <= item.query_node;
			txfree_q <= item.tx_free;
		end
		if ((state_q == ST_SCAN) && !scan_end)
			eval_idx_s1 <= scan_q[PB-1:0];
		if (state_q == ST_RESULT) begin
			result.send_frame     <= sent_q;
			result.tx_repeat_bit  <= sent_q & need_q;
			result.frame_accepted <= acc_q;
			result.all_can_sleep  <= (n_req_q == '0);
			result.online_count   <= n_online_q;
			result.query_online   <= query_online;
		end
	end

endmodule

// ===== rtl/cnm_checker.sv =====
// Port-level checker for the node monitor, attached to the top level by bind.
// Depends on cnm_pkg for the beat types.
module cnm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input cnm_pkg::result_t result
);

	// A result beat only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted beat occupies the block and gives no result in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted beat did not occupy the block");

	// A beat is either a frame or a tick, never both sending and accepting
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.send_frame && result.frame_accepted))
		else $error("send and frame accept in one result");

	// The repeat bit is only reported with a sent frame
	a_rep_send: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.send_frame) |-> !result.tx_repeat_bit)
		else $error("repeat bit without send");

	// Online count never exceeds the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.online_count <= 9'(cnm_pkg::MAX_PEERS)))
		else $error("online count beyond table size");

endmodule

bind can_network_node_monitor cnm_checker u_cnm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== tb/cnm_node_table_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the CAN network-management node monitor: mirrors the peer table,
// the millisecond clock and the send timer, and scores every result beat in order.
// Depends on cnm_pkg for the beat structs and the register map.
module cnm_node_table_checker
	import cnm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  item_t               item,
	input  logic                done,
	input  result_t             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output int unsigned         mismatches,
	output int unsigned         awaiting
);

	// register shadows
	logic        need_q;
	logic [7:0]  own_q;
	logic [10:0] base_q;
	logic [15:0] tmo_q;
	logic [15:0] period_q;

	// node state
	logic [TIME_BITS-1:0] clock_ms;
	logic [TIME_BITS-1:0] last_tx_ms;
	logic                 running;
	logic                 peer_up    [MAX_PEERS];
	logic                 peer_req   [MAX_PEERS];
	logic [TIME_BITS-1:0] peer_stamp [MAX_PEERS];
	int unsigned          up_count;
	int unsigned          req_count;

	result_t expected_status [$];

	task automatic advance_node_table(input item_t it, output result_t r);
		int   n;
		logic want_tx;
		r = '0;
		if (it.action == ACT_FRAME) begin
			n = int'(it.can_id) - int'(base_q);
			if (n >= 0 && n < MAX_PEERS && n != int'(own_q)) begin
				if (!peer_up[n]) begin
					peer_up[n]  = 1'b1;
					peer_req[n] = 1'b0;
					up_count++;
				end
				if (peer_req[n] && !it.ctrl_byte[0])
					req_count--;
				else if (!peer_req[n] && it.ctrl_byte[0])
					req_count++;
				peer_req[n]   = it.ctrl_byte[0];
				peer_stamp[n] = clock_ms;
				r.frame_accepted = 1'b1;
			end
		end else begin
			clock_ms = clock_ms + 1'b1;
			// age out silent peers
			for (int p = 0; p < MAX_PEERS; p++) begin
				if (peer_up[p] && (clock_ms - peer_stamp[p]) >= TIME_BITS'(tmo_q)) begin
					peer_up[p] = 1'b0;
					up_count--;
					if (peer_req[p])
						req_count--;
					peer_req[p] = 1'b0;
				end
			end
			if (!running) begin
				want_tx = 1'b1;
				running = 1'b1;
			end else
				want_tx = (clock_ms - last_tx_ms) >= TIME_BITS'(period_q);
			if (want_tx && it.tx_free) begin
				r.send_frame    = 1'b1;
				r.tx_repeat_bit = need_q;
				last_tx_ms      = clock_ms;
			end
		end
		r.all_can_sleep = (req_count == 0);
		r.online_count  = CNT_BITS'(up_count);
		r.query_online  = (it.query_node == own_q) || peer_up[it.query_node];
	endtask

	task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			need_q     = RST_NETWORK_NEED;
			own_q      = RST_OWN_NODE_ID;
			base_q     = RST_ID_BASE;
			tmo_q      = RST_OFFLINE_TMO;
			period_q   = RST_SEND_PERIOD;
			clock_ms   = '0;
			last_tx_ms = '0;
			running    = 1'b0;
			up_count   = 0;
			req_count  = 0;
			for (int p = 0; p < MAX_PEERS; p++) begin
				peer_up[p]    = 1'b0;
				peer_req[p]   = 1'b0;
				peer_stamp[p] = '0;
			end
			expected_status.delete();
			mismatches = 0;
			awaiting  <= 0;
		end else begin
			if (done) begin
				if (expected_status.size() == 0) begin
					$display("%0t: result beat mismatch, expected none, actual %h",
						$time, result);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("send_frame", 9'(want.send_frame), 9'(result.send_frame));
					check_field("tx_repeat_bit", 9'(want.tx_repeat_bit),
						9'(result.tx_repeat_bit));
					check_field("frame_accepted", 9'(want.frame_accepted),
						9'(result.frame_accepted));
					check_field("all_can_sleep", 9'(want.all_can_sleep),
						9'(result.all_can_sleep));
					check_field("online_count", want.online_count, result.online_count);
					check_field("query_online", 9'(want.query_online),
						9'(result.query_online));
				end
			end
			if (start && !busy) begin
				advance_node_table(item, want);
				expected_status.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_NETWORK_NEED:   need_q   = pwdata[0];
					REG_OWN_NODE_ID:    own_q    = pwdata[7:0];
					REG_ID_WINDOW_BASE: base_q   = pwdata[10:0];
					REG_OFFLINE_TMO:    tmo_q    = pwdata[15:0];
					REG_SEND_PERIOD:    period_q = pwdata[15:0];
					default: ;
				endcase
			end
			awaiting <= expected_status.size();
		end
	end

endmodule

// ===== tb/can_network_node_monitor_test.sv =====
`timescale 1ns / 100ps
// Top of the node monitor regression: clock, reset, frame and tick beats, APB setup.
// Depends on cnm_pkg, can_network_node_monitor and cnm_node_table_checker.
module can_network_node_monitor_test;
	import cnm_pkg::*;

	localparam int ITEMS = 900;
	// The slowest quiet stretch is a tick beat behind an idle burst and a register phase.
	localparam int WATCHDOG = 3000;
	localparam int TAIL     = 300;

	logic              clk;
	logic              arst_n;
	logic              start;
	item_t             cmd_item;
	logic              busy;
	logic              done;
	result_t           cmd_result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned quiet;

	// stimulus-side view of the current setup, used only to aim frames and queries at the window
	logic [7:0]  own_id;
	logic [10:0] win_base;
	logic [7:0]  pool [6];
	logic        wide_phase;
	int          idle_pct;
	int          n_issued;

	can_network_node_monitor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (cmd_item),
		.busy    (busy),
		.done    (done),
		.result  (cmd_result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cnm_node_table_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (cmd_item),
		.done       (done),
		.result     (cmd_result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any command or result beat restarts the count.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet <= 0;
		else if ((start && !busy) || done)
			quiet <= 0;
		else if (quiet >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	function automatic item_t pack_item(input logic act, input logic [10:0] id,
			input logic [7:0] ctrl, input logic [7:0] query, input logic txf);
		item_t it;
		it.action     = act;
		it.can_id     = id;
		it.ctrl_byte  = ctrl;
		it.query_node = query;
		it.tx_free    = txf;
		return it;
	endfunction

	// Mostly well-formed traffic: frames from this phase's peers landing in the window,
	// with ticks mixed in so peers age out and periodic sends come due.
	function automatic item_t make_item();
		item_t it;
		int    n;
		int    k;
		it.action    = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_FRAME;
		it.ctrl_byte = 8'($urandom_range(0, 255));
		it.tx_free   = ($urandom_range(0, 3) != 0);
		k = $urandom_range(0, 99);
		if (wide_phase && k < 60)
			n = $urandom_range(0, 255);
		else if (k < 70)
			n = int'(pool[$urandom_range(0, 5)]);
		else if (k < 80)
			n = int'(own_id);
		else if (k < 90)
			n = $urandom_range(0, 299);
		else
			n = -1;
		if (n >= 0 && int'(win_base) + n <= 2047)
			it.can_id = 11'(int'(win_base) + n);
		else
			it.can_id = 11'($urandom_range(0, 2047));
		k = $urandom_range(0, 99);
		if (k < 50)
			it.query_node = pool[$urandom_range(0, 5)];
		else if (k < 65)
			it.query_node = own_id;
		else
			it.query_node = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Present one beat and hold it until the block takes it; start stays high on return.
	task automatic issue(input item_t it);
		logic taken;
		if (n_issued < ITEMS - 120 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start    <= 1'b1;
		cmd_item <= it;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		n_issued++;
	endtask

	// Drop start and hold until every expected result beat has arrived.
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
		@(posedge clk);
	endtask

	// Setup and access phases; psel stays high so writes can run back to back.
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		logic rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic configure(input logic need, input logic [7:0] own, input logic [10:0] base,
			input logic [15:0] tmo, input logic [15:0] period);
		settle();
		write_reg(REG_NETWORK_NEED, DATA_W'(need));
		write_reg(REG_OWN_NODE_ID, DATA_W'(own));
		write_reg(REG_ID_WINDOW_BASE, DATA_W'(base));
		write_reg(REG_OFFLINE_TMO, DATA_W'(tmo));
		write_reg(REG_SEND_PERIOD, DATA_W'(period));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		own_id   = own;
		win_base = base;
	endtask

	initial begin
		int          k;
		int          len;
		logic        need;
		logic [7:0]  own;
		logic [10:0] base;
		logic [15:0] tmo;
		logic [15:0] period;

		arst_n   <= 1'b0;
		start    <= 1'b0;
		cmd_item <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		own_id     = RST_OWN_NODE_ID;
		win_base   = RST_ID_BASE;
		wide_phase = 1'b0;
		idle_pct   = 0;
		n_issued   = 0;
		foreach (pool[i])
			pool[i] = 8'(i);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-on setup: first tick with a busy mailbox only starts the node,
		// then frames around the window edges, own node and beyond the table.
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd1,   1'b0));
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd0,   1'b1));
		issue(pack_item(ACT_FRAME, 11'd1280, 8'hFF, 8'd0,   1'b0));
		issue(pack_item(ACT_FRAME, 11'd1281, 8'h01, 8'd1,   1'b1));
		issue(pack_item(ACT_FRAME, 11'd1279, 8'h01, 8'd2,   1'b0));
		issue(pack_item(ACT_FRAME, 11'd1535, 8'h00, 8'd255, 1'b1));
		issue(pack_item(ACT_FRAME, 11'd1536, 8'h01, 8'd0,   1'b0));
		issue(pack_item(ACT_FRAME, 11'd2047, 8'h01, 8'hFF,  1'b1));
		// refresh an online peer and withdraw its request
		issue(pack_item(ACT_FRAME, 11'd1280, 8'hFE, 8'd0,   1'b0));
		issue(pack_item(ACT_FRAME, 11'd0,    8'h55, 8'hAA,  1'b1));

		// Zero timeout and zero period: every tick clears the table and wants to send.
		configure(1'b0, 8'hFF, 11'd0, 16'd0, 16'd0);
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd0,   1'b1));
		issue(pack_item(ACT_FRAME, 11'd255,  8'h01, 8'hFF,  1'b0));
		issue(pack_item(ACT_FRAME, 11'd2047, 8'h01, 8'h55,  1'b1));
		issue(pack_item(ACT_FRAME, 11'd3,    8'h01, 8'd3,   1'b0));
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd3,   1'b0));
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd3,   1'b1));

		// Largest window base, largest timeout and period.
		configure(1'b1, 8'h00, 11'd2047, 16'hFFFF, 16'hFFFF);
		issue(pack_item(ACT_FRAME, 11'd2047, 8'h01, 8'd0,   1'b1));
		issue(pack_item(ACT_FRAME, 11'd2046, 8'h01, 8'd0,   1'b1));
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd0,   1'b1));

		// Window ending exactly at the top identifier, one-millisecond timeout.
		configure(1'b1, 8'h80, 11'd1792, 16'd1, 16'd1);
		issue(pack_item(ACT_FRAME, 11'd2047, 8'h01, 8'd255, 1'b0));
		issue(pack_item(ACT_FRAME, 11'd1792, 8'h01, 8'd0,   1'b1));
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd255, 1'b1));
		issue(pack_item(ACT_TICK,  11'd0,    8'h00, 8'd0,   1'b1));

		// Random phases, each behind a full drain and a fresh register setup.
		while (n_issued < ITEMS) begin
			need = 1'($urandom_range(0, 1));
			k = $urandom_range(0, 9);
			own = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			k = $urandom_range(0, 9);
			base = (k == 0) ? 11'd0 : (k == 1) ? 11'd2047 : (k == 2) ? 11'd1280 :
				11'($urandom_range(0, 1792));
			k = $urandom_range(0, 9);
			tmo = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF : (k == 2) ? 16'd1 :
				16'($urandom_range(2, 40));
			k = $urandom_range(0, 9);
			period = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF : (k == 2) ? 16'd1 :
				16'($urandom_range(2, 30));
			configure(need, own, base, tmo, period);
			foreach (pool[i])
				pool[i] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 2) == 0)
				pool[0] = own;
			wide_phase = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 2);
			idle_pct = (k == 0) ? 0 : (k == 1) ? 15 : 40;
			len = $urandom_range(40, 120);
			repeat (len)
				if (n_issued < ITEMS)
					issue(make_item());
		end

		// Drain, then leave room for any stray result beat before the verdict.
		settle();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cnm_pkg.sv
rtl/can_network_node_monitor.sv
rtl/cnm_checker.sv
tb/cnm_node_table_checker.sv
tb/can_network_node_monitor_test.sv
